/* sv/qnr_pkg.sv */
`timescale 1ns / 1ps

package qnr_pkg;

    typedef logic [1:0] t_status;

    localparam t_status ST_CONVERGED  = 2'd0;
    localparam t_status ST_FLAT_DERIV = 2'd1;
    localparam t_status ST_LIMIT      = 2'd2;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 3'd6;
    localparam int NUM_COEF  = 6;
    localparam int PORT_W    = 64;
    localparam int CNT_W     = 17;
    localparam int LIMIT_W   = 16;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd500;

endpackage

/* sv/qnr_mul_unit.sv */
`timescale 1ns / 1ps

module qnr_mul_unit #(
    parameter int W = 64,
    parameter int F = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    output logic                o_done,
    output logic signed [W-1:0] o_res
);

    logic [63:0]  r_a, r_b;
    logic         r_neg;
    logic [127:0] r_acc;
    logic [63:0]  r_pp;
    logic [6:0]   r_sh;
    logic [2:0]   r_cnt;
    logic         r_busy;
    logic         r_done;
    logic signed [W-1:0] r_res;

    logic [W-1:0]   ma, mb;
    logic [127:0]   val;
    logic [127:0]   lim;
    logic signed [W-1:0] sat;

    always_comb begin
        ma  = i_a[W-1] ? W'(-i_a) : W'(i_a);
        mb  = i_b[W-1] ? W'(-i_b) : W'(i_b);
        val = r_acc >> F;
        lim = 128'({1'b0, {(W-1){1'b1}}}) + 128'(r_neg);
        if (val > lim) begin
            sat = r_neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            sat = r_neg ? -W'(val) : W'(val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= 64'(ma);
                r_b    <= 64'(mb);
                r_neg  <= i_a[W-1] ^ i_b[W-1];
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt < 3'd4) begin
                    r_pp <= 64'(r_a[{r_cnt[1], 5'b0} +: 32]) * 64'(r_b[{r_cnt[0], 5'b0} +: 32]);
                    r_sh <= {2'(r_cnt[1]) + 2'(r_cnt[0]), 5'b0};
                end
                if (r_cnt >= 3'd1 && r_cnt <= 3'd4) begin
                    r_acc <= r_acc + (128'(r_pp) << r_sh);
                end
                if (r_cnt == 3'd5) begin
                    r_res  <= sat;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

/* sv/qnr_div_unit.sv */
`timescale 1ns / 1ps

module qnr_div_unit #(
    parameter int W = 64,
    parameter int F = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [W-1:0] i_num,
    input  logic signed [W-1:0] i_den,
    output logic                o_done,
    output logic signed [W-1:0] o_quo
);

    localparam int NW = W + F;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_q;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_md;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic signed [W-1:0] r_quo;

    logic [W-1:0]  mn, md;
    logic [W:0]    trial;
    logic          qbit;
    logic [W-1:0]  rem_nx;
    logic [NW-1:0] lim;
    logic signed [W-1:0] sat;

    always_comb begin
        mn    = i_num[W-1] ? W'(-i_num) : W'(i_num);
        md    = i_den[W-1] ? W'(-i_den) : W'(i_den);
        trial = {r_rem, r_q[NW-1]};
        qbit  = trial >= {1'b0, r_md};
        rem_nx = qbit ? W'(trial - {1'b0, r_md}) : W'(trial);
        lim   = NW'({1'b0, {(W-1){1'b1}}}) + NW'(r_neg);
        if (r_q > lim) begin
            sat = r_neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            sat = r_neg ? -W'(r_q) : W'(r_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= NW'(mn) << F;
                r_rem  <= '0;
                r_md   <= md;
                r_neg  <= i_num[W-1] ^ i_den[W-1];
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt == CW'(NW)) begin
                    r_quo  <= sat;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    r_rem <= rem_nx;
                    r_q   <= {r_q[NW-2:0], qbit};
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* sv/quintic_newton_root_finder_top.sv */
`timescale 1ns / 1ps
// one request at a time: input stalls from acceptance until the result is loaded
// each newton update uses the shared 4-step multiplier and the bit-serial restoring divider
// a converged result reports at most iteration_limit updates; the limit status reports iteration_limit+1
// synchronous active-low reset: coefficients 0, limit 500, sequencer idle, no result

module quintic_newton_root_finder_top #(
    parameter int DATA_WIDTH = 64,
    parameter int FRAC_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_initial_guess,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_root_estimate,
    output logic [16:0] o_iteration_count,
    output logic [1:0]  o_status,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam int W  = DATA_WIDTH;
    localparam int WX = W + 4;
    localparam longint unsigned TOL_RAW =
        ((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000;
    localparam logic [W-1:0] TOL = W'((TOL_RAW == 0) ? 64'd1 : TOL_RAW);
    localparam logic signed [WX-1:0] SMAX = {5'b00000, {(W-1){1'b1}}};
    localparam logic signed [WX-1:0] SMIN = {5'b11111, {(W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_GO, S_MUL_WAIT, S_ADD, S_PCHK, S_DCHK,
        S_DIV_GO, S_DIV_WAIT, S_UPD, S_DONE
    } t_state;

    t_state r_state;
    logic signed [W-1:0] r_coef [0:qnr_pkg::NUM_COEF-1];
    logic [qnr_pkg::LIMIT_W-1:0] r_limit;
    logic signed [W-1:0] r_x, r_acc, r_poly;
    logic [qnr_pkg::CNT_W-1:0] r_cnt;
    logic [2:0] r_k;
    logic       r_deriv;
    qnr_pkg::t_status r_stat;
    logic        r_out_valid;
    logic [63:0] r_out_root;
    logic [16:0] r_out_cnt;
    qnr_pkg::t_status r_out_stat;

    logic mul_start, mul_done, div_start, div_done;
    logic signed [W-1:0] mul_res, div_quo;

    function automatic logic signed [W-1:0] clamp(input logic signed [WX-1:0] v);
        if (v > SMAX) begin
            return SMAX[W-1:0];
        end else if (v < SMIN) begin
            return SMIN[W-1:0];
        end
        return v[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] scale(input logic signed [W-1:0] c,
                                                  input logic [2:0] k);
        logic signed [WX-1:0] e;
        e = WX'(c);
        case (k)
            3'd5:    return clamp(e + (e <<< 2));
            3'd4:    return clamp(e <<< 2);
            3'd3:    return clamp(e + (e <<< 1));
            3'd2:    return clamp(e <<< 1);
            default: return c;
        endcase
    endfunction

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] a);
        return a[W-1] ? W'(-a) : W'(a);
    endfunction

    logic signed [W-1:0] term, sum_add, x_upd;
    logic [qnr_pkg::CNT_W-1:0] cnt_nx;

    always_comb begin
        term    = r_deriv ? scale(r_coef[r_k], 3'd5 - r_k) : r_coef[r_k];
        sum_add = clamp(WX'(mul_res) + WX'(term));
        x_upd   = clamp(WX'(r_x) - WX'(div_quo));
        cnt_nx  = r_cnt + 1'b1;
    end

    assign mul_start = (r_state == S_MUL_GO);
    assign div_start = (r_state == S_DIV_GO);

    qnr_mul_unit #(.W(W), .F(FRAC_BITS)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_a(r_acc), .i_b(r_x), .o_done(mul_done), .o_res(mul_res)
    );

    qnr_div_unit #(.W(W), .F(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(r_poly), .i_den(r_acc), .o_done(div_done), .o_quo(div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < qnr_pkg::NUM_COEF; i++) begin
                r_coef[i] <= '0;
            end
            r_limit     <= qnr_pkg::LIMIT_RESET;
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_x         <= '0;
            r_cnt       <= '0;
            r_poly      <= '0;
            r_acc       <= '0;
            r_k         <= '0;
            r_deriv     <= 1'b0;
            r_stat      <= qnr_pkg::ST_CONVERGED;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == qnr_pkg::CFG_LIMIT) begin
                    r_limit <= i_cfg_data[qnr_pkg::LIMIT_W-1:0];
                end else if (i_cfg_index < qnr_pkg::CFG_LIMIT) begin
                    r_coef[i_cfg_index] <= i_cfg_data[W-1:0];
                end
            end
            if (r_state == S_DONE && (!r_out_valid || !i_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_x     <= i_initial_guess[W-1:0];
                        r_cnt   <= '0;
                        r_acc   <= r_coef[0];
                        r_k     <= 3'd1;
                        r_deriv <= 1'b0;
                        r_state <= S_MUL_GO;
                    end
                end
                S_MUL_GO:   r_state <= S_MUL_WAIT;
                S_MUL_WAIT: if (mul_done) r_state <= S_ADD;
                S_ADD: begin
                    r_acc <= sum_add;
                    r_k   <= r_k + 3'd1;
                    if (r_deriv && r_k == 3'd4) begin
                        r_state <= S_DCHK;
                    end else if (!r_deriv && r_k == 3'd5) begin
                        r_state <= S_PCHK;
                    end else begin
                        r_state <= S_MUL_GO;
                    end
                end
                S_PCHK: begin
                    r_poly <= r_acc;
                    if (mag(r_acc) < TOL) begin
                        r_stat  <= qnr_pkg::ST_CONVERGED;
                        r_state <= S_DONE;
                    end else begin
                        r_acc   <= scale(r_coef[0], 3'd5);
                        r_k     <= 3'd1;
                        r_deriv <= 1'b1;
                        r_state <= S_MUL_GO;
                    end
                end
                S_DCHK: begin
                    if (mag(r_acc) <= TOL) begin
                        r_stat  <= qnr_pkg::ST_FLAT_DERIV;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DIV_GO;
                    end
                end
                S_DIV_GO:   r_state <= S_DIV_WAIT;
                S_DIV_WAIT: if (div_done) r_state <= S_UPD;
                S_UPD: begin
                    r_x   <= x_upd;
                    r_cnt <= cnt_nx;
                    if (cnt_nx > {1'b0, r_limit}) begin
                        r_stat  <= qnr_pkg::ST_LIMIT;
                        r_state <= S_DONE;
                    end else begin
                        r_acc   <= r_coef[0];
                        r_k     <= 3'd1;
                        r_deriv <= 1'b0;
                        r_state <= S_MUL_GO;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_root  <= 64'(r_x);
                        r_out_cnt   <= r_cnt;
                        r_out_stat  <= r_stat;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall           = (r_state != S_IDLE);
    assign o_valid           = r_out_valid;
    assign o_root_estimate   = r_out_root;
    assign o_iteration_count = r_out_cnt;
    assign o_status          = r_out_stat;

endmodule

/* sv/qnr_checker.sv */
`timescale 1ns / 1ps

module qnr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [16:0] o_iteration_count,
    input logic [1:0]  o_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == qnr_pkg::ST_CONVERGED ||
                     o_status == qnr_pkg::ST_FLAT_DERIV ||
                     o_status == qnr_pkg::ST_LIMIT))
        else $error("bad status code");

    a_limit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == qnr_pkg::ST_LIMIT |-> o_iteration_count != 17'd0)
        else $error("limit status with zero updates");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after request");

endmodule

bind quintic_newton_root_finder_top qnr_checker u_qnr_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall),
    .o_iteration_count(o_iteration_count), .o_status(o_status)
);

/* tb/quintic_newton_root_finder_top_tb.sv */
`timescale 1ns / 1ps

module quintic_newton_root_finder_top_tb;

    localparam logic [qnr_pkg::CFG_IDX_W-1:0] REG_C5 = 3'd0;
    localparam logic [qnr_pkg::CFG_IDX_W-1:0] REG_C4 = 3'd1;
    localparam logic [qnr_pkg::CFG_IDX_W-1:0] REG_C3 = 3'd2;
    localparam logic [qnr_pkg::CFG_IDX_W-1:0] REG_C2 = 3'd3;
    localparam logic [qnr_pkg::CFG_IDX_W-1:0] REG_C1 = 3'd4;
    localparam logic [qnr_pkg::CFG_IDX_W-1:0] REG_C0 = 3'd5;
    localparam logic [qnr_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;
    localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] Q_ONE = 64'sh1_0000_0000;
    localparam logic [63:0] TOL = 64'd4295;
    localparam int IDLE_LIMIT = 200000;

    typedef struct packed {
        logic [63:0]      root;
        logic [16:0]      count;
        qnr_pkg::t_status status;
    } t_root_result;

    logic        i_clk, i_rst_n;
    logic        i_valid, i_stall, i_cfg_wr_en;
    logic [63:0] i_initial_guess, i_cfg_data;
    logic [2:0]  i_cfg_index;
    logic        o_stall, o_valid;
    logic [63:0] o_root_estimate;
    logic [16:0] o_iteration_count;
    logic [1:0]  o_status;

    quintic_newton_root_finder_top dut (.*);

    logic signed [63:0] coef [qnr_pkg::NUM_COEF];
    logic [qnr_pkg::LIMIT_W-1:0] iter_limit;
    t_root_result       pending_roots [$];
    int errors, n_sent, n_checked, n_flat, n_limit, n_conv;
    int hold_len, stall_left, idle_cycles;
    bit no_idle;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [63:0] magn(logic signed [63:0] a);
        return a < 0 ? 64'd0 - a : a;
    endfunction

    function automatic logic signed [63:0] sat_mag(bit neg, logic [127:0] m);
        if (neg) return (m > 128'h8000_0000_0000_0000) ? Q_MIN : 64'd0 - m[63:0];
        return (m > 128'h7FFF_FFFF_FFFF_FFFF) ? Q_MAX : m[63:0];
    endfunction

    function automatic logic signed [63:0] q_add(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [64:0] s;
        s = a + b;
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return Q_MAX;
        if (s < -65'sh0_8000_0000_0000_0000) return Q_MIN;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] q_sub(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [64:0] s;
        s = a - b;
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return Q_MAX;
        if (s < -65'sh0_8000_0000_0000_0000) return Q_MIN;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] q_mul(logic signed [63:0] a, logic signed [63:0] b);
        logic [127:0] m;
        m = {64'd0, magn(a)} * {64'd0, magn(b)};
        return sat_mag((a < 0) != (b < 0), m >> 32);
    endfunction

    function automatic logic signed [63:0] q_div(logic signed [63:0] n, logic signed [63:0] d);
        logic [127:0] num;
        num = {64'd0, magn(n)} << 32;
        return sat_mag((n < 0) != (d < 0), num / {64'd0, magn(d)});
    endfunction

    function automatic logic signed [63:0] poly_at(logic signed [63:0] x);
        logic signed [63:0] acc;
        acc = coef[0];
        for (int i = 1; i < qnr_pkg::NUM_COEF; i++) acc = q_add(q_mul(acc, x), coef[i]);
        return acc;
    endfunction

    function automatic logic signed [63:0] deriv_at(logic signed [63:0] x);
        logic signed [63:0] acc, sc;
        acc = 0;
        for (int i = 0; i < qnr_pkg::NUM_COEF - 1; i++) begin
            sc = 0;
            for (int k = 0; k < qnr_pkg::NUM_COEF - 1 - i; k++) sc = q_add(sc, coef[i]);
            acc = (i == 0) ? sc : q_add(q_mul(acc, x), sc);
        end
        return acc;
    endfunction

    function automatic t_root_result newton_solve(logic signed [63:0] guess);
        t_root_result r;
        logic signed [63:0] x, p, d, q;
        int cnt;
        x = guess;
        cnt = 0;
        r.status = qnr_pkg::ST_CONVERGED;
        p = poly_at(x);
        while (magn(p) >= TOL) begin
            d = deriv_at(x);
            if (magn(d) <= TOL) begin
                r.status = qnr_pkg::ST_FLAT_DERIV;
                break;
            end
            q = q_div(p, d);
            x = q_sub(x, q);
            cnt++;
            if (cnt > iter_limit) begin
                r.status = qnr_pkg::ST_LIMIT;
                break;
            end
            p = poly_at(x);
        end
        r.root = x;
        r.count = cnt[16:0];
        return r;
    endfunction

    function automatic int draw_gap();
        if (no_idle) return 0;
        return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 40);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic signed [63:0] rand_small();
        logic signed [35:0] t;
        t = {$urandom, $urandom};
        return t;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx < qnr_pkg::NUM_COEF) coef[idx] = val;
        else if (idx == qnr_pkg::CFG_LIMIT) iter_limit = val[qnr_pkg::LIMIT_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic set_poly(logic signed [63:0] c5, c4, c3, c2, c1, c0, logic [15:0] lim);
        write_reg(REG_C5, c5);
        write_reg(REG_C4, c4);
        write_reg(REG_C3, c3);
        write_reg(REG_C2, c2);
        write_reg(REG_C1, c1);
        write_reg(REG_C0, c0);
        write_reg(qnr_pkg::CFG_LIMIT, {48'd0, lim});
    endtask

    task automatic send_guess(logic signed [63:0] g);
        int gap;
        i_valid <= 1'b1;
        i_initial_guess <= g;
        do @(posedge i_clk); while (o_stall);
        pending_roots.push_back(newton_solve(g));
        n_sent++;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_roots.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else if (hold_len > 0) begin
            i_stall <= 1'b1;
            hold_len--;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
            if (!no_idle && $urandom_range(0, 3) == 0) stall_left = draw_gap();
        end
    end

    always @(posedge i_clk) begin
        t_root_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_roots.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
            end else begin
                want = pending_roots.pop_front();
                n_checked++;
                case (want.status)
                    qnr_pkg::ST_FLAT_DERIV: n_flat++;
                    qnr_pkg::ST_LIMIT:      n_limit++;
                    default:                n_conv++;
                endcase
                if (o_root_estimate !== want.root) begin
                    $error("root_estimate exp %h got %h", want.root, o_root_estimate);
                    errors++;
                end
                if (o_iteration_count !== want.count) begin
                    $error("iteration_count exp %0d got %0d", want.count, o_iteration_count);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, o_status);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic test_reset_defaults();
        send_guess(0);
        send_guess(Q_MAX);
        send_guess(Q_MIN);
        send_guess(rand64());
        wait_idle();
    endtask

    task automatic test_quadratic();
        set_poly(0, 0, 0, Q_ONE, 0, -2 * Q_ONE, 16'd500);
        send_guess(Q_ONE);
        send_guess(-Q_ONE);
        send_guess(3 * Q_ONE);
        send_guess(64'sd1);
        wait_idle();
    endtask

    task automatic test_flat_derivative();
        set_poly(0, 0, 0, Q_ONE, 0, Q_ONE, 16'd20);
        send_guess(0);
        send_guess(Q_ONE);
        wait_idle();
    endtask

    task automatic test_limit_edges();
        set_poly(0, 0, 0, Q_ONE, 0, -2 * Q_ONE, 16'd0);
        send_guess(Q_ONE);
        send_guess(Q_MAX);
        wait_idle();
        set_poly(0, 0, 0, 0, 0, 0, 16'hFFFF);
        send_guess(Q_MIN);
        wait_idle();
    endtask

    task automatic test_extreme_coefs();
        set_poly(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 16'd3);
        send_guess(Q_MAX);
        send_guess(Q_MIN);
        wait_idle();
        set_poly(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 16'd3);
        send_guess(Q_MIN);
        send_guess(Q_ONE);
        wait_idle();
    endtask

    task automatic test_unknown_register();
        set_poly(0, 0, Q_ONE, 0, -Q_ONE, 0, 16'd8);
        write_reg(REG_NONE, rand64());
        send_guess(2 * Q_ONE);
        send_guess(-(Q_ONE >>> 1));
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        set_poly(0, 0, 0, Q_ONE, 0, -3 * Q_ONE, 16'd10);
        no_idle = 1;
        hold_len = 3000;
        for (int i = 0; i < 4; i++) send_guess(Q_ONE + rand_small());
        no_idle = 0;
        wait_idle();
    endtask

    task automatic test_random();
        logic [63:0] c [qnr_pkg::NUM_COEF];
        int kind;
        logic signed [63:0] g;
        for (int ph = 0; ph < 19; ph++) begin
            kind = $urandom_range(0, 9);
            for (int i = 0; i < qnr_pkg::NUM_COEF; i++) begin
                if (kind < 6) c[i] = ($urandom_range(0, 2) == 0) ? 64'd0 : rand_small();
                else if (kind < 9) c[i] = rand64();
                else c[i] = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
            end
            no_idle = (ph % 5 == 2);
            set_poly(c[0], c[1], c[2], c[3], c[4], c[5],
                     ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 20))
                                                 : 16'($urandom_range(0, 7)));
            for (int n = 0; n < 30; n++) begin
                case ($urandom_range(0, 9))
                    0: g = rand64();
                    1: g = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
                    default: g = rand_small();
                endcase
                send_guess(g);
            end
            wait_idle();
        end
        no_idle = 0;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_initial_guess <= '0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        for (int i = 0; i < qnr_pkg::NUM_COEF; i++) coef[i] = 0;
        iter_limit = qnr_pkg::LIMIT_RESET;
        hold_len = 0;
        no_idle = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_quadratic();
        test_flat_derivative();
        test_limit_edges();
        test_extreme_coefs();
        test_unknown_register();
        test_output_backpressure();
        test_random();
        wait_idle();
        repeat (200) @(posedge i_clk);
        $display("sent %0d guesses, checked %0d results", n_sent, n_checked);
        $display("converged %0d, flat derivative %0d, limit hit %0d", n_conv, n_flat, n_limit);
        if (errors == 0 && pending_roots.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
